### hw/rtl/huffman_code_builder_defines.svh
// Assertion macros shared by the Huffman code builder.
`ifndef HUFFMAN_CODE_BUILDER_DEFINES_SVH
`define HUFFMAN_CODE_BUILDER_DEFINES_SVH

`ifndef ASSERT_OFF
`define HCB_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");
`define HCB_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define HCB_ASSERT(lbl, cond)
`define HCB_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

### hw/rtl/hcb_pkg.sv
`timescale 1ns / 1ps
package hcb_pkg;

  localparam int MAX_SYMBOLS = 16;
  localparam int NODE_COUNT  = 2 * MAX_SYMBOLS - 1;
  localparam int NIW         = $clog2(NODE_COUNT);
  localparam int CW          = $clog2(MAX_SYMBOLS + 1);
  localparam int SIW         = $clog2(MAX_SYMBOLS);
  localparam int LW          = $clog2(MAX_SYMBOLS);
  localparam int WW          = 16 + $clog2(MAX_SYMBOLS);
  localparam int CODE_W      = 15;
  localparam int CLEN_W      = 4;

  typedef struct packed {
    logic [7:0]  symbol;
    logic [15:0] weight;
    logic        last;
  } in_t;

  typedef struct packed {
    logic [7:0]        out_symbol;
    logic [CODE_W-1:0] code_bits;
    logic [CLEN_W-1:0] code_length;
    logic              overflow;
    logic              final_res;
  } out_t;

  // Running pair of the two smallest parentless nodes seen so far.
  typedef struct packed {
    logic           fv;
    logic [NIW-1:0] fi;
    logic [WW-1:0]  fw;
    logic           sv;
    logic [NIW-1:0] si;
    logic [WW-1:0]  sw;
  } cand_t;

  // Broadcast commands from the sequencer to every cell.
  typedef struct packed {
    logic           ld_en;
    logic [NIW-1:0] ld_idx;
    logic [WW-1:0]  ld_w;
    logic           mg_en;
    logic [NIW-1:0] mg_first;
    logic [NIW-1:0] mg_second;
    logic [NIW-1:0] mg_top;
    logic [WW-1:0]  mg_w;
    logic           clr;
  } cell_ctl_t;

  // Link status a cell reports for the code walk.
  typedef struct packed {
    logic           hp;
    logic           right;
    logic [NIW-1:0] parent;
  } cell_st_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SCAN_GO,
    ST_SCAN,
    ST_WALK,
    ST_EMIT
  } state_t;

endpackage

### hw/rtl/hcb_node_cell.sv
`timescale 1ns / 1ps
module hcb_node_cell (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [hcb_pkg::NIW-1:0] idx,
  input  hcb_pkg::cell_ctl_t      ctl,
  input  logic                    tok_in,
  input  hcb_pkg::cand_t          cand_in,
  output logic                    tok_out,
  output hcb_pkg::cand_t          cand_out,
  output hcb_pkg::cell_st_t       st
);

  logic                    live_r;
  logic                    hp_r;
  logic                    right_r;
  logic [hcb_pkg::NIW-1:0] parent_r;
  logic [hcb_pkg::WW-1:0]  weight_r;
  logic                    tok_r;
  hcb_pkg::cand_t          cand_r;
  hcb_pkg::cand_t          cand_nxt;

  // Fold this node into the passing pair. Earlier cells have lower indices,
  // so only a strictly smaller weight displaces a held candidate.
  always_comb begin
    cand_nxt = cand_in;
    if (live_r && !hp_r) begin
      if (!cand_in.fv || weight_r < cand_in.fw) begin
        cand_nxt.sv = cand_in.fv;
        cand_nxt.si = cand_in.fi;
        cand_nxt.sw = cand_in.fw;
        cand_nxt.fv = 1'b1;
        cand_nxt.fi = idx;
        cand_nxt.fw = weight_r;
      end else if (!cand_in.sv || weight_r < cand_in.sw) begin
        cand_nxt.sv = 1'b1;
        cand_nxt.si = idx;
        cand_nxt.sw = weight_r;
      end
    end
  end

  // Control bits: node present and parent link valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r <= 1'b0;
      hp_r   <= 1'b0;
      tok_r  <= 1'b0;
    end else begin
      tok_r <= tok_in;
      if (ctl.clr) begin
        live_r <= 1'b0;
        hp_r   <= 1'b0;
      end else if (ctl.ld_en && ctl.ld_idx == idx) begin
        live_r <= 1'b1;
        hp_r   <= 1'b0;
      end else if (ctl.mg_en) begin
        if (ctl.mg_top == idx) begin
          live_r <= 1'b1;
          hp_r   <= 1'b0;
        end else if (ctl.mg_first == idx || ctl.mg_second == idx) begin
          hp_r <= 1'b1;
        end
      end
    end
  end

  // Node payload.
  always_ff @(posedge clk) begin
    cand_r <= cand_nxt;
    if (ctl.ld_en && ctl.ld_idx == idx) begin
      weight_r <= ctl.ld_w;
    end else if (ctl.mg_en) begin
      if (ctl.mg_top == idx) begin
        weight_r <= ctl.mg_w;
      end
      if (ctl.mg_first == idx) begin
        parent_r <= ctl.mg_top;
        right_r  <= 1'b0;
      end
      if (ctl.mg_second == idx) begin
        parent_r <= ctl.mg_top;
        right_r  <= 1'b1;
      end
    end
  end

  assign tok_out   = tok_r;
  assign cand_out  = cand_r;
  assign st.hp     = hp_r;
  assign st.right  = right_r;
  assign st.parent = parent_r;

endmodule

### hw/rtl/huffman_code_builder.sv
`timescale 1ns / 1ps
// After the request with last, each merge runs a scan token along the row of node cells
// and then merges the two smallest parentless nodes; each code is then found by walking
// the parent links up from its leaf, and the result is handed out.
// Requests are taken one per cycle while loading and are stalled during build and output.
// Reset (rst_n low, synchronous) empties the store, clears overflow and every node's link-valid bit.
`include "huffman_code_builder_defines.svh"
module huffman_code_builder (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  hcb_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output hcb_pkg::out_t out_data
);

  localparam int NC  = hcb_pkg::NODE_COUNT;
  localparam int NIW = hcb_pkg::NIW;
  localparam int CW  = hcb_pkg::CW;

  hcb_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]               count_r, count_nxt;
  logic                        dropped_r, dropped_nxt;
  logic [NIW-1:0]              top_r, top_nxt;
  logic [hcb_pkg::SIW-1:0]     s_r, s_nxt;
  logic [NIW-1:0]              j_r, j_nxt;
  logic [hcb_pkg::LW-1:0]      len_r, len_nxt;
  logic [hcb_pkg::CODE_W-1:0]  code_r, code_nxt;
  hcb_pkg::out_t               out_r, out_nxt;
  logic [7:0]                  sym_mem [hcb_pkg::MAX_SYMBOLS];

  hcb_pkg::cell_ctl_t ctl;
  logic               tok [NC+1];
  hcb_pkg::cand_t     cand [NC+1];
  hcb_pkg::cell_st_t  st [NC];
  hcb_pkg::cell_st_t  cur;
  logic               in_acc, out_acc, store_ok, tail_tok;

  // Row of node cells; the scan token and candidate pair ripple one cell a cycle.
  genvar g;
  generate
    for (g = 0; g < NC; g++) begin : g_cell
      hcb_node_cell u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .idx     (NIW'(g)),
        .ctl     (ctl),
        .tok_in  (tok[g]),
        .cand_in (cand[g]),
        .tok_out (tok[g+1]),
        .cand_out(cand[g+1]),
        .st      (st[g])
      );
    end
  endgenerate

  assign tok[0]   = (state_r == hcb_pkg::ST_SCAN_GO);
  assign cand[0]  = '0;
  assign tail_tok = tok[NC];
  assign cur      = st[j_r];

  assign in_stall  = (state_r != hcb_pkg::ST_LOAD);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = (state_r == hcb_pkg::ST_EMIT);
  assign out_acc   = out_valid && !out_stall;
  assign out_data  = out_r;
  assign store_ok  = count_r < CW'(hcb_pkg::MAX_SYMBOLS);

  // Sequencer: load, scan and merge, walk codes, hand out results.
  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    dropped_nxt = dropped_r;
    top_nxt     = top_r;
    s_nxt       = s_r;
    j_nxt       = j_r;
    len_nxt     = len_r;
    code_nxt    = code_r;
    out_nxt     = out_r;
    ctl           = '0;
    ctl.ld_idx    = NIW'(count_r);
    ctl.ld_w      = hcb_pkg::WW'(in_data.weight);
    ctl.mg_first  = cand[NC].fi;
    ctl.mg_second = cand[NC].si;
    ctl.mg_top    = top_r;
    ctl.mg_w      = cand[NC].fw + cand[NC].sw;
    unique case (state_r)
      hcb_pkg::ST_LOAD: begin
        if (in_acc) begin
          if (store_ok) begin
            ctl.ld_en = 1'b1;
            count_nxt = count_r + CW'(1);
          end else begin
            dropped_nxt = 1'b1;
          end
          if (in_data.last) begin
            top_nxt  = NIW'(count_nxt);
            s_nxt    = '0;
            j_nxt    = '0;
            len_nxt  = '0;
            code_nxt = '0;
            if (count_nxt < CW'(2)) begin
              state_nxt = hcb_pkg::ST_WALK;
            end else begin
              state_nxt = hcb_pkg::ST_SCAN_GO;
            end
          end
        end
      end
      hcb_pkg::ST_SCAN_GO: begin
        state_nxt = hcb_pkg::ST_SCAN;
      end
      hcb_pkg::ST_SCAN: begin
        if (tail_tok) begin
          ctl.mg_en = 1'b1;
          top_nxt   = top_r + NIW'(1);
          if ((NIW+1)'(top_r) + (NIW+1)'(1) ==
              (NIW+1)'({count_r, 1'b0}) - (NIW+1)'(1)) begin
            state_nxt = hcb_pkg::ST_WALK;
          end else begin
            state_nxt = hcb_pkg::ST_SCAN_GO;
          end
        end
      end
      hcb_pkg::ST_WALK: begin
        if (cur.hp) begin
          if (cur.right) begin
            code_nxt = code_r | (hcb_pkg::CODE_W'(1) << len_r);
          end
          len_nxt = len_r + hcb_pkg::LW'(1);
          j_nxt   = cur.parent;
        end else begin
          out_nxt.out_symbol  = sym_mem[s_r];
          out_nxt.code_bits   = code_r;
          out_nxt.code_length = hcb_pkg::CLEN_W'(len_r);
          out_nxt.overflow    = dropped_r;
          out_nxt.final_res   = (CW'(s_r) + CW'(1) == count_r);
          state_nxt           = hcb_pkg::ST_EMIT;
        end
      end
      hcb_pkg::ST_EMIT: begin
        if (out_acc) begin
          len_nxt  = '0;
          code_nxt = '0;
          if (out_r.final_res) begin
            ctl.clr     = 1'b1;
            count_nxt   = '0;
            dropped_nxt = 1'b0;
            state_nxt   = hcb_pkg::ST_LOAD;
          end else begin
            s_nxt     = s_r + hcb_pkg::SIW'(1);
            j_nxt     = NIW'(s_nxt);
            state_nxt = hcb_pkg::ST_WALK;
          end
        end
      end
      default: state_nxt = hcb_pkg::ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= hcb_pkg::ST_LOAD;
      count_r   <= '0;
      dropped_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      dropped_r <= dropped_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_r  <= top_nxt;
    s_r    <= s_nxt;
    j_r    <= j_nxt;
    len_r  <= len_nxt;
    code_r <= code_nxt;
    out_r  <= out_nxt;
    if (in_acc && store_ok) begin
      sym_mem[count_r[hcb_pkg::SIW-1:0]] <= in_data.symbol;
    end
  end

  // The scan reaches the end of the row with two candidates.
  `HCB_ASSERT(a_merge_pair, !(state_r == hcb_pkg::ST_SCAN && tail_tok) || (cand[NC].fv && cand[NC].sv))
  // Only one scan token is in flight at a time.
  `HCB_ASSERT(a_one_token, !(state_r == hcb_pkg::ST_SCAN && tok[NC] && tok[1]))
  // After the final code is taken the block is loading again.
  `HCB_ASSERT_NEXT(a_back_to_load, out_acc && out_data.final_res, state_r == hcb_pkg::ST_LOAD && count_r == '0)

endmodule
